/* rtl/iprtl_pkg.sv */
// Shared types, command codes and sizes for the IPv4 range table lookup.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package iprtl_pkg;

  // Sizes fixed by the field widths.
  localparam int unsigned PREFIX_DEPTH    = 256;
  localparam int unsigned IDX_W           = 17;
  localparam int unsigned SLOT_W          = 16;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned OFF_W           = 24;
  localparam int unsigned LEN_W           = 8;
  localparam int unsigned IN_DATA_W       = 136;
  localparam int unsigned OUT_DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned DEF_MAX_RECORDS = 65536;

  // Input command codes carried in tuser.
  typedef enum logic [1:0] {
    CMD_WR_PREFIX = 2'd0,
    CMD_WR_RECORD = 2'd1,
    CMD_LOOKUP    = 2'd2
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } bk_state_t;

  // One entry of the queue between front and back.
  // For a lookup, idx is the bucket start and addr the query address.
  // For a record write, idx is the slot and addr the end address.
  typedef struct packed {
    logic              is_lookup;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
  } job_t;

  // One stored range record.
  typedef struct packed {
    logic [ADDR_W-1:0] end_addr;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
  } rec_t;

endpackage

/* rtl/iprtl_front.sv */
// Front end: accepts input words, applies prefix writes and resolves the
// bucket start of lookups. Holds the prefix table. Depends on iprtl_pkg.
`timescale 1ns / 1ps

module iprtl_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [iprtl_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          job_vld,
  input  logic                          job_rdy,
  output iprtl_pkg::job_t               job
);
  import iprtl_pkg::*;

  logic [IDX_W-1:0]  pfx_mem [PREFIX_DEPTH];
  logic [IDX_W-1:0]  pfx_rd_r;

  logic              s1_vld_r, s1_vld_nxt;
  logic              s1_lookup_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [OFF_W-1:0]  s1_off_r;
  logic [LEN_W-1:0]  s1_len_r;

  logic [SLOT_W-1:0] f_slot;
  logic [IDX_W-1:0]  f_start;
  logic [ADDR_W-1:0] f_end;
  logic [OFF_W-1:0]  f_off;
  logic [LEN_W-1:0]  f_len;
  logic [ADDR_W-1:0] f_query;
  cmd_t              cmd;
  logic              acc;
  logic              wr_pfx, to_stage;

  // Unpack the input word.
  assign f_slot  = in_tdata[15:0];
  assign f_start = in_tdata[32:16];
  assign f_end   = in_tdata[64:33];
  assign f_off   = in_tdata[88:65];
  assign f_len   = in_tdata[96:89];
  assign f_query = in_tdata[128:97];
  assign cmd     = cmd_t'(in_tuser);

  assign in_tready = !s1_vld_r || job_rdy;
  assign acc       = in_tvalid && in_tready;

  // Classify the accepted word.
  always_comb begin
    wr_pfx   = 1'b0;
    to_stage = 1'b0;
    case (cmd)
      CMD_WR_PREFIX: wr_pfx   = acc && (f_slot[SLOT_W-1:8] == '0);
      CMD_WR_RECORD: to_stage = acc;
      CMD_LOOKUP:    to_stage = acc;
      default:       to_stage = 1'b0;
    endcase
  end

  // Prefix table with registered read at lookup acceptance.
  always_ff @(posedge clk) begin
    if (wr_pfx) begin
      pfx_mem[f_slot[7:0]] <= f_start;
    end
    if (acc && cmd == CMD_LOOKUP) begin
      pfx_rd_r <= pfx_mem[f_query[31:24]];
    end
  end

  // Stage register valid.
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (to_stage) begin
      s1_vld_nxt = 1'b1;
    end else if (job_rdy) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (to_stage) begin
      s1_lookup_r <= (cmd == CMD_LOOKUP);
      s1_slot_r   <= f_slot;
      s1_addr_r   <= (cmd == CMD_LOOKUP) ? f_query : f_end;
      s1_off_r    <= f_off;
      s1_len_r    <= f_len;
    end
  end

  assign job_vld       = s1_vld_r;
  assign job.is_lookup = s1_lookup_r;
  assign job.idx       = s1_lookup_r ? pfx_rd_r : {1'b0, s1_slot_r};
  assign job.addr      = s1_addr_r;
  assign job.offset    = s1_off_r;
  assign job.length    = s1_len_r;

endmodule

/* rtl/iprtl_queue.sv */
// Short queue of jobs between the front end and the back end.
// Depends on iprtl_pkg for the job type and depth.
`timescale 1ns / 1ps

module iprtl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_vld,
  output logic            push_rdy,
  input  iprtl_pkg::job_t push_job,
  output logic            pop_vld,
  input  logic            pop_rdy,
  output iprtl_pkg::job_t pop_job
);
  import iprtl_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_rdy = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;
  assign pop_job  = mem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/iprtl_back.sv */
// Back end: applies record writes and runs the record scan of lookups.
// Holds the record table and the limit register. Depends on iprtl_pkg.
`timescale 1ns / 1ps

module iprtl_back #(
  parameter int unsigned MAX_RECORDS = iprtl_pkg::DEF_MAX_RECORDS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [iprtl_pkg::IDX_W-1:0]      cfg_wr_data,
  input  logic                             job_vld,
  output logic                             job_rdy,
  input  iprtl_pkg::job_t                  job,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [iprtl_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tuser
);
  import iprtl_pkg::*;

  localparam int unsigned RIDX_W = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W  = (RIDX_W + 1 > IDX_W) ? RIDX_W + 1 : IDX_W;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_RECORDS);

  rec_t              rec_mem [MAX_RECORDS];
  rec_t              rec_rd_r;

  bk_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] query_r, query_nxt;
  logic [IDX_W-1:0]  lim_cfg_r;
  logic              res_found_r, res_found_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  logic [LEN_W-1:0]  res_len_r, res_len_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_found_r;
  logic [OFF_W-1:0]  out_off_r;
  logic [LEN_W-1:0]  out_len_r;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  job_idx;
  logic [CNT_W-1:0]  idx_inc;
  logic              rd_en, wr_en, out_load;
  logic [CNT_W-1:0]  rd_idx;

  // Scan limit saturated to the table capacity.
  always_comb begin
    lim = CNT_W'(lim_cfg_r);
    if (lim > MAX_C) begin
      lim = MAX_C;
    end
  end

  assign job_idx = CNT_W'(job.idx);
  assign idx_inc = CNT_W'(idx_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_cfg_r <= '0;
    end else if (cfg_wr_en) begin
      lim_cfg_r <= cfg_wr_data;
    end
  end

  // Sequencer: one record read per cycle during a scan.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    query_nxt     = query_r;
    res_found_nxt = res_found_r;
    res_off_nxt   = res_off_r;
    res_len_nxt   = res_len_r;
    job_rdy       = 1'b0;
    rd_en         = 1'b0;
    rd_idx        = idx_r;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        job_rdy = 1'b1;
        if (job_vld) begin
          if (!job.is_lookup) begin
            wr_en = (job_idx < MAX_C);
          end else if (job_idx >= lim) begin
            res_found_nxt = 1'b0;
            res_off_nxt   = '0;
            res_len_nxt   = '0;
            state_nxt     = BK_EMIT;
          end else begin
            rd_en     = 1'b1;
            rd_idx    = job_idx;
            idx_nxt   = job_idx;
            query_nxt = job.addr;
            state_nxt = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (rec_rd_r.end_addr >= query_r) begin
          res_found_nxt = (rec_rd_r.length != '0);
          res_off_nxt   = (rec_rd_r.length != '0) ? rec_rd_r.offset : '0;
          res_len_nxt   = rec_rd_r.length;
          state_nxt     = BK_EMIT;
        end else if (idx_inc >= lim) begin
          res_found_nxt = 1'b0;
          res_off_nxt   = '0;
          res_len_nxt   = '0;
          state_nxt     = BK_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_idx  = idx_inc;
          idx_nxt = idx_inc;
        end
      end
      BK_EMIT: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    query_r     <= query_nxt;
    res_found_r <= res_found_nxt;
    res_off_r   <= res_off_nxt;
    res_len_r   <= res_len_nxt;
    if (out_load) begin
      out_found_r <= res_found_r;
      out_off_r   <= res_off_r;
      out_len_r   <= res_len_r;
    end
  end

  // Record table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[job_idx[RIDX_W-1:0]] <= '{end_addr: job.addr, offset: job.offset,
                                        length: job.length};
    end
    if (rd_en) begin
      rec_rd_r <= rec_mem[rd_idx[RIDX_W-1:0]];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_len_r, out_off_r};
  assign out_tuser  = out_found_r;

endmodule

/* rtl/ip_range_table_lookup_top.sv */
// Top level of the IPv4 range table lookup: front end, job queue, back end.
// Depends on iprtl_pkg, iprtl_front, iprtl_queue and iprtl_back.
//
// Usage:
//   Input words arrive on in_*; in_tuser holds the command (write prefix
//   entry, write range record, look up address). Write commands give no
//   result. A lookup gives one result word on out_*: out_tdata holds the
//   record's offset and length, out_tuser says whether a match was found.
//   The user must write the limit register through cfg_wr_en / cfg_wr_data
//   only while the block is idle; the block itself does not enforce this.
// Timing:
//   A lookup passes the front-end stage register and the job queue, then the
//   back end scans its bucket, reading one record per cycle from the single
//   read port of the record table, and takes no new job from the queue until
//   the result is loaded into the output register. Record writes are applied
//   by the back end while it is idle; prefix writes never reach it.
// Reset and stall:
//   Synchronous active-low reset empties the pipeline, the queue and the
//   output register and clears the limit to zero; table contents are kept
//   but must be rewritten before use. When out_tready is low the result
//   word holds, the back end waits, and the queue and front end keep taking
//   input words until the queue is full.
`timescale 1ns / 1ps

module ip_range_table_lookup_top #(
  parameter int unsigned MAX_RECORDS = iprtl_pkg::DEF_MAX_RECORDS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: slot[15:0], prefix_start[32:16], end_ip[64:33],
  // rec_offset[88:65], rec_length[96:89], query_ip[128:97], zero pad.
  input  logic [iprtl_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [1:0]                       in_tuser,
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: data_offset[23:0], data_length[31:24].
  output logic [iprtl_pkg::OUT_DATA_W-1:0] out_tdata,
  // Fields from bit 0: found[0].
  output logic                             out_tuser,
  // Configuration: record_limit.
  input  logic                             cfg_wr_en,
  input  logic [iprtl_pkg::IDX_W-1:0]      cfg_wr_data
);
  import iprtl_pkg::*;

  logic fq_vld, fq_rdy;
  job_t fq_job;
  logic qb_vld, qb_rdy;
  job_t qb_job;

  iprtl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job_vld   (fq_vld),
    .job_rdy   (fq_rdy),
    .job       (fq_job)
  );

  iprtl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (fq_vld),
    .push_rdy (fq_rdy),
    .push_job (fq_job),
    .pop_vld  (qb_vld),
    .pop_rdy  (qb_rdy),
    .pop_job  (qb_job)
  );

  iprtl_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .job_vld     (qb_vld),
    .job_rdy     (qb_rdy),
    .job         (qb_job),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for ip_range_table_lookup_top: loads prefix and range
// tables, runs lookups under random stalls and compares every result word.
// Depends on iprtl_pkg and the RTL of the lookup block.
`timescale 1ns / 1ps

module tb_top;
  import iprtl_pkg::*;

  // Command code that the block must ignore.
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned MAX_REC        = DEF_MAX_RECORDS;
  localparam int          SETTLE_CYCLES  = 24;
  localparam int          STALL_LIMIT    = 4000;
  localparam int          ITEMS_PER_MODE = 290;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] slot;
    logic [16:0] pstart;
    logic [31:0] end_ip;
    logic [23:0] offset;
    logic [7:0]  length;
    logic [31:0] query;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [23:0] offset;
    logic [7:0]  length;
  } hit_t;

  // Mirror of both tables and the limit register, plus the lookup results
  // still owed by the block.
  class lookup_scoreboard;
    logic [16:0] bucket_start [PREFIX_DEPTH];
    bit          bucket_set   [PREFIX_DEPTH];
    logic [31:0] rec_end      [MAX_REC];
    logic [23:0] rec_off      [MAX_REC];
    logic [7:0]  rec_len      [MAX_REC];
    bit          rec_set      [MAX_REC];
    logic [16:0] record_limit = '0;
    hit_t        pending [$];
    int          errors = 0;

    // Walks the bucket as the block does. Returns 0 if the walk would touch
    // a table entry that was never written.
    function bit scan_bucket(input logic [31:0] query, output hit_t hit);
      logic [7:0]  bucket;
      int unsigned stop;
      int unsigned i;
      bucket = query[31:24];
      hit = '0;
      stop = (32'(record_limit) > MAX_REC) ? MAX_REC : 32'(record_limit);
      if (!bucket_set[bucket]) return 1'b0;
      for (i = 32'(bucket_start[bucket]); i < stop; i++) begin
        if (!rec_set[i]) return 1'b0;
        if (rec_end[i] >= query) begin
          if (rec_len[i] != '0) hit = {1'b1, rec_off[i], rec_len[i]};
          return 1'b1;
        end
      end
      return 1'b1;
    endfunction

    // Applies one accepted input word to the mirror.
    function void note_word(input in_word_t w);
      hit_t hit;
      case (w.cmd)
        CMD_WR_PREFIX: begin
          if (32'(w.slot) < PREFIX_DEPTH) begin
            bucket_start[w.slot[7:0]] = w.pstart;
            bucket_set[w.slot[7:0]] = 1'b1;
          end
        end
        CMD_WR_RECORD: begin
          if (32'(w.slot) < MAX_REC) begin
            rec_end[w.slot] = w.end_ip;
            rec_off[w.slot] = w.offset;
            rec_len[w.slot] = w.length;
            rec_set[w.slot] = 1'b1;
          end
        end
        CMD_LOOKUP: begin
          void'(scan_bucket(w.query, hit));
          pending.push_back(hit);
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted result word with the oldest owed result.
    function void check_word(input logic found, input logic [23:0] offset,
                             input logic [7:0] length);
      hit_t want;
      if (pending.size() == 0) begin
        $error("result word with no lookup pending: found %0d offset 0x%06h length %0d",
               found, offset, length);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        errors++;
      end
      if (offset !== want.offset) begin
        $error("data_offset: expected 0x%06h, got 0x%06h", want.offset, offset);
        errors++;
      end
      if (length !== want.length) begin
        $error("data_length: expected %0d, got %0d", want.length, length);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // Fields from bit 0: slot, prefix_start, end_ip, rec_offset, rec_length, query_ip.
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  // Fields from bit 0: cmd.
  logic [1:0]            in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // Fields from bit 0: data_offset, data_length.
  logic [OUT_DATA_W-1:0] out_tdata;
  // Fields from bit 0: found.
  logic                  out_tuser;
  logic                  cfg_wr_en   = 1'b0;
  logic [IDX_W-1:0]      cfg_wr_data = '0;

  lookup_scoreboard sb = new;
  int send_idle = 0;
  int recv_idle = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  ip_range_table_lookup_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver side: random backpressure at the current idle rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tuser, out_tdata[23:0], out_tdata[31:24]);
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Fills every field with random content; callers set the ones that matter.
  function automatic in_word_t any_word(input logic [1:0] cmd);
    in_word_t w;
    w.cmd    = cmd;
    w.slot   = 16'($urandom);
    w.pstart = 17'($urandom_range(0, 65536));
    w.end_ip = $urandom;
    w.offset = 24'($urandom);
    w.length = 8'($urandom);
    w.query  = $urandom;
    return w;
  endfunction

  // Offers one input word, with random idle cycles ahead of it.
  task automatic push_word(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, w.query, w.length, w.offset, w.end_ip, w.pstart, w.slot};
    in_tuser  <= w.cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(w);
    if (w.cmd != CMD_UNUSED && !(w.cmd == CMD_WR_PREFIX && 32'(w.slot) >= PREFIX_DEPTH))
      items_sent++;
  endtask

  task automatic write_prefix(input logic [15:0] slot, input logic [16:0] start);
    in_word_t w;
    w = any_word(CMD_WR_PREFIX);
    w.slot = slot;
    w.pstart = start;
    push_word(w);
  endtask

  task automatic write_record(input logic [15:0] slot, input logic [31:0] end_ip,
                              input logic [23:0] offset, input logic [7:0] length);
    in_word_t w;
    w = any_word(CMD_WR_RECORD);
    w.slot = slot;
    w.end_ip = end_ip;
    w.offset = offset;
    w.length = length;
    push_word(w);
  endtask

  // Sends a lookup only if its bucket walk stays on written entries.
  task automatic send_lookup(input logic [31:0] query, output bit sent);
    in_word_t w;
    hit_t probe;
    sent = sb.scan_bucket(query, probe);
    if (sent) begin
      w = any_word(CMD_LOOKUP);
      w.query = query;
      push_word(w);
    end
  endtask

  // Holds the sender until every owed result is back and queued writes are done.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[IDX_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.record_limit = value[IDX_W-1:0];
  endtask

  // Hand-picked words: field extremes, ignored writes, zero length and the
  // scan stopping at the limit or starting past it.
  task automatic directed_checks();
    bit sent;
    set_limit(3);
    write_prefix(16'h0000, 17'd0);
    write_prefix(16'h0080, 17'd1);
    write_prefix(16'h00FF, 17'd2);
    write_record(16'd0, 32'h0000_0000, 24'hFF_FFFF, 8'hFF);
    write_record(16'd1, 32'h8000_0000, 24'hAB_CDEF, 8'h00);
    write_record(16'd2, 32'hFFFF_FFFE, 24'h12_3456, 8'h01);
    send_lookup(32'h0000_0000, sent);
    send_lookup(32'h0000_0001, sent);
    send_lookup(32'h8000_0001, sent);
    send_lookup(32'hFFFF_FFFF, sent);
    write_prefix(16'h00FF, 17'd65536);
    send_lookup(32'hFF00_0000, sent);
    // Out-of-range prefix slots must not alias onto slots 0 and 255.
    write_prefix(16'h0100, 17'd2);
    write_prefix(16'hFFFF, 17'd1);
    push_word(any_word(CMD_UNUSED));
    send_lookup(32'h0000_0000, sent);
    send_lookup(32'hFF12_3456, sent);
    write_record(16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
    write_record(16'd3, 32'hFFFF_FFFF, 24'h00_0000, 8'h80);
    send_lookup(32'h80FF_FFFF, sent);
    write_prefix(16'h00FF, 17'd2);
    send_lookup(32'hFFFF_FFFF, sent);
  endtask

  // One table load followed by a burst of lookups mixed with stray words.
  task automatic run_epoch(input int epoch_no);
    logic [31:0] ends [64];
    logic [31:0] tmp;
    logic [31:0] query;
    logic [7:0]  octet;
    logic [7:0]  bucket;
    logic [16:0] start;
    int n, base, i, j, k, tries, n_lookups;
    bit sent;
    settle();
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    case ($urandom_range(0, 3))
      0, 1: base = 0;
      2: base = 65536 - n;
      default: base = $urandom_range(0, 65536 - n);
    endcase
    case (epoch_no)
      0: set_limit(0);
      1: set_limit(131071);
      2: set_limit(65536);
      default: begin
        case ($urandom_range(0, 3))
          0: set_limit(base + n);
          1: set_limit($urandom_range(0, base + n));
          2: set_limit($urandom_range(base + n, 131071));
          default: set_limit(131071);
        endcase
      end
    endcase

    // Sorted end addresses clustered in eight neighboring first octets.
    octet = 8'($urandom_range(0, 248));
    for (i = 0; i < n; i++) begin
      ends[i] = $urandom;
      if ($urandom_range(0, 5) != 0) ends[i][31:24] = 8'(octet + $urandom_range(0, 7));
    end
    for (i = 1; i < n; i++) begin
      tmp = ends[i];
      j = i;
      while (j > 0 && ends[j-1] > tmp) begin
        ends[j] = ends[j-1];
        j--;
      end
      ends[j] = tmp;
    end
    if ($urandom_range(0, 3) != 0) ends[n-1] = 32'hFFFF_FFFF;
    for (i = 0; i < n; i++)
      write_record(16'(base + i), ends[i], 24'($urandom),
                   ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));

    // Buckets point at the first record able to hold their addresses, or at random.
    for (k = 0; k < 10; k++) begin
      bucket = (k < 8) ? 8'(octet + k) : 8'($urandom);
      start = 17'd65536;
      for (i = n - 1; i >= 0; i--)
        if (ends[i] >= {bucket, 24'h0}) start = 17'(base + i);
      if ($urandom_range(0, 7) == 0) start = 17'(base + $urandom_range(0, n - 1));
      write_prefix({8'd0, bucket}, start);
    end

    n_lookups = $urandom_range(20, 50);
    for (k = 0; k < n_lookups; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: push_word(any_word(CMD_UNUSED));
          1: write_prefix(16'($urandom_range(256, 65535)), 17'($urandom_range(0, 65536)));
          2: write_record(16'($urandom), $urandom, 24'($urandom), 8'($urandom));
          default: write_prefix(16'(octet + $urandom_range(0, 7)),
                                ($urandom_range(0, 1) == 0) ? 17'd65536
                                                            : 17'(base + $urandom_range(0, n - 1)));
        endcase
      end
      sent = 1'b0;
      for (tries = 0; tries < 40 && !sent; tries++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            query = $urandom;
            query[31:24] = 8'(octet + $urandom_range(0, 7));
          end
          6, 7, 8: query = ends[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
          default: query = $urandom;
        endcase
        send_lookup(query, sent);
      end
    end
  endtask

  initial begin
    int mode;
    int epoch_no;
    send_idle = 26;
    recv_idle = 59;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();

    // Three stall patterns: slow receiver, slow sender, then no idling.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle = 26;
          recv_idle = 59;
        end
        1: begin
          send_idle = 59;
          recv_idle = 26;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      epoch_no = 0;
      while (items_sent < 30 + (mode + 1) * ITEMS_PER_MODE) begin
        run_epoch(epoch_no);
        epoch_no++;
      end
    end

    settle();
    repeat (26) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
